>>> rtl/core/wbps_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the wildcard byte pattern scan
// no dependencies
package wbps_pkg;

  localparam int PatLen     = 16;
  localparam int OffsetBits = 32;
  localparam int WinLen     = PatLen - 1;
  localparam int LenW       = $clog2(PatLen + 1);
  localparam int IdxW       = $clog2(PatLen);
  localparam int CfgLenW    = 5;
  localparam int AddrW      = 5;
  localparam int DataW      = 64;
  localparam int MaskW      = 16;
  localparam int ResOffW    = 32;

  // register indexes, paddr[4:3]
  localparam logic [1:0] RegPatternLow  = 2'd0;
  localparam logic [1:0] RegPatternHigh = 2'd1;
  localparam logic [1:0] RegWildMask    = 2'd2;
  localparam logic [1:0] RegPatternLen  = 2'd3;

  typedef logic [7:0] byte_t;

  // decoded configuration seen by the scan datapath
  typedef struct packed {
    byte_t [PatLen-1:0] pat;
    logic  [PatLen-1:0] wild;
    logic  [LenW-1:0]   len_m1;
  } cfg_t;

  // what one window cell compares against
  typedef struct packed {
    byte_t pat;
    logic  wild;
    logic  used;
  } cell_cfg_t;

endpackage

>>> rtl/core/wbps_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for input and result words
// depends on wbps_pkg
interface wbps_in_if;
  import wbps_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  import wbps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [ResOffW-1:0]   match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

>>> rtl/core/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// top level of the wildcard byte pattern scan: window cells, count, result register
// depends on wbps_pkg, wbps_if, wbps_cfg_regs, wbps_cell
//
//  channel  dir  handshake         payload
//  in_i     in   valid / ready     data_byte[7:0], last_byte
//  out_o    out  valid / ready     found, match_offset[31:0]
//  apb      in   psel / penable    paddr[4:3] register, pwdata[63:0], prdata[63:0]
//
// one word is taken every cycle while in_i.ready is high; the only stored stage is the result register,
// so a byte is compared in the cycle it arrives and its result shows in the cycle after
// the window cells shift one byte per cycle, only in cycles where an input word is taken
// in_i.ready drops only while a result waits in the result register and out_o.ready is low
// reset clears count, reported flag and result valid; window bytes are not cleared,
// the count gate keeps stale bytes out of a compare
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  wbps_in_if.sink          in_i,
  wbps_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam logic [OffsetBits-1:0] CountMax = '1;

  cfg_t cfg;

  wbps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  logic in_fire, out_fire;
  logic out_valid_q, out_valid_d;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_valid_q & out_o.ready;

  // window: cell k holds the byte seen k+1 words ago
  byte_t     win_byte [WinLen];
  logic      cell_hit [WinLen];
  cell_cfg_t cell_cfg [WinLen];
  logic [WinLen-1:0] hits;

  for (genvar k = 0; k < WinLen; k++) begin : g_cell
    logic [LenW-1:0] pat_idx;

    // cell k lines up with pattern byte len-2-k
    assign pat_idx          = cfg.len_m1 - LenW'(k + 1);
    assign cell_cfg[k].used = LenW'(k) < cfg.len_m1;
    assign cell_cfg[k].pat  = cfg.pat[pat_idx[IdxW-1:0]];
    assign cell_cfg[k].wild = cfg.wild[pat_idx[IdxW-1:0]];

    if (k == 0) begin : g_head
      wbps_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (in_fire),
        .byte_i  (in_i.data_byte),
        .cfg_i   (cell_cfg[k]),
        .byte_o  (win_byte[k]),
        .hit_o   (cell_hit[k])
      );
    end else begin : g_body
      wbps_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (in_fire),
        .byte_i  (win_byte[k-1]),
        .cfg_i   (cell_cfg[k]),
        .byte_o  (win_byte[k]),
        .hit_o   (cell_hit[k])
      );
    end
    assign hits[k] = cell_hit[k];
  end

  // the arriving byte is checked against the final pattern byte
  logic cur_hit;
  assign cur_hit = cfg.wild[cfg.len_m1[IdxW-1:0]] |
                   (in_i.data_byte == cfg.pat[cfg.len_m1[IdxW-1:0]]);

  // region count and match bookkeeping
  logic [OffsetBits-1:0] count_q, count_d;
  logic                  reported_q, reported_d;
  logic                  count_ok, match, emit;
  logic [OffsetBits-1:0] offset;

  assign count_ok = count_q >= OffsetBits'(cfg.len_m1);
  assign offset   = count_q - OffsetBits'(cfg.len_m1);
  assign match    = ~reported_q & count_ok & cur_hit & (&hits);
  assign emit     = match | (~reported_q & in_i.last_byte);

  always_comb begin
    count_d    = count_q;
    reported_d = reported_q;
    if (in_fire) begin
      if (in_i.last_byte) begin
        count_d    = '0;
        reported_d = 1'b0;
      end else begin
        reported_d = reported_q | match;
        if (count_q != CountMax) begin
          count_d = count_q + OffsetBits'(1);
        end
      end
    end
  end

  // result register
  logic               found_q;
  logic [ResOffW-1:0] match_offset_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      found_q        <= match;
      match_offset_q <= match ? ResOffW'(offset) : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = match_offset_q;

`ifndef SYNTHESIS
  // a new result never lands on one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit |-> !out_valid_q || out_o.ready)
    else $error("result register overwritten");

  // the last byte of a region always restarts the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last_byte |=> count_q == '0 && !reported_q)
    else $error("scan not cleared after last byte");

  // a not-found result carries a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> match_offset_q == '0)
    else $error("offset set on a not-found result");

  // once a match is reported no further result comes in that region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> !emit)
    else $error("second result in one region");

  // count steps by one per non-final byte until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.last_byte && count_q != CountMax |=> count_q == $past(count_q) + 1'b1)
    else $error("byte count slipped");
`endif

endmodule

>>> rtl/core/wbps_cfg_regs.sv
`timescale 1ns / 1ps
// apb register block: pattern, wildcard mask and length
// depends on wbps_pkg
module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [DataW-1:0]   pat_low_q, pat_low_d;
  logic [DataW-1:0]   pat_high_q, pat_high_d;
  logic [MaskW-1:0]   wild_q, wild_d;
  logic [CfgLenW-1:0] len_q, len_d;
  logic [1:0]         reg_idx;
  logic               wr_en;
  logic [LenW-1:0]    len_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    pat_low_d  = pat_low_q;
    pat_high_d = pat_high_q;
    wild_d     = wild_q;
    len_d      = len_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPatternLow:  pat_low_d  = pwdata;
        RegPatternHigh: pat_high_d = pwdata;
        RegWildMask:    wild_d     = pwdata[MaskW-1:0];
        RegPatternLen:  len_d      = pwdata[CfgLenW-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= CfgLenW'(1);
    end else begin
      pat_low_q  <= pat_low_d;
      pat_high_q <= pat_high_d;
      wild_q     <= wild_d;
      len_q      <= len_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPatternLow:  prdata = pat_low_q;
      RegPatternHigh: prdata = pat_high_q;
      RegWildMask:    prdata = DataW'(wild_q);
      RegPatternLen:  prdata = DataW'(len_q);
      default:        prdata = '0;
    endcase
  end

  // zero length acts as one, oversize length clamps to PatLen
  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (int'(len_q) > PatLen) begin
      len_eff = LenW'(PatLen);
    end else begin
      len_eff = LenW'(len_q);
    end
  end

  always_comb begin
    cfg_o.len_m1 = len_eff - LenW'(1);
    for (int i = 0; i < PatLen; i++) begin
      if (i < 8) begin
        cfg_o.pat[i]  = pat_low_q[8*i +: 8];
        cfg_o.wild[i] = wild_q[i];
      end else if (i < 16) begin
        cfg_o.pat[i]  = pat_high_q[8*(i-8) +: 8];
        cfg_o.wild[i] = wild_q[i];
      end else begin
        cfg_o.pat[i]  = '0;
        cfg_o.wild[i] = 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/wbps_cell.sv
`timescale 1ns / 1ps
// one window cell: holds a past byte, passes it on, compares it
// depends on wbps_pkg
module wbps_cell
  import wbps_pkg::*;
(
  input  logic      clk_i,
  input  logic      shift_i,
  input  byte_t     byte_i,
  input  cell_cfg_t cfg_i,
  output byte_t     byte_o,
  output logic      hit_o
);

  byte_t byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // unused cells never block a match
  assign hit_o  = ~cfg_i.used | cfg_i.wild | (byte_q == cfg_i.pat);

endmodule

>>> tb/sv/wbps_scan_checker.sv
`timescale 1ns / 1ps
// result checker for the wildcard byte pattern scan: watches both word channels
// and the register port, predicts each result and compares; needs wbps_pkg, wbps_if
module wbps_scan_checker
  import wbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  wbps_in_if               in_mon,
  wbps_out_if              out_mon,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);

  typedef struct packed {
    logic               found;
    logic [ResOffW-1:0] offset;
  } scan_result_t;

  // copy of the register file
  logic [DataW-1:0]   pat_low;
  logic [DataW-1:0]   pat_high;
  logic [MaskW-1:0]   wild;
  logic [CfgLenW-1:0] pat_len;

  // scan state; history[0] is the newest byte
  byte_t              history [WinLen];
  logic [OffsetBits-1:0] byte_count;
  logic               reported;

  scan_result_t       expected_q [$];
  int                 n_fail = 0;
  int                 n_pending = 0;
  int                 n_results = 0;

  assign fail_count    = n_fail;
  assign pending_count = n_pending;
  assign result_count  = n_results;

  task automatic clear_scan();
    foreach (history[k]) history[k] = '0;
    byte_count = '0;
    reported   = 1'b0;
  endtask

  task automatic scan_word(input byte_t b, input logic last);
    int           span;
    logic         hit;
    byte_t        seen;
    logic [127:0] pat;
    scan_result_t res;
    pat  = {pat_high, pat_low};
    span = (pat_len == 0) ? 1 : (pat_len > PatLen) ? PatLen : int'(pat_len);
    // no match before span bytes of the region have arrived
    hit  = (byte_count >= OffsetBits'(span - 1));
    for (int i = 0; i < span; i++) begin
      seen = (i == span - 1) ? b : history[span - 2 - i];
      if (!wild[i] && seen != pat[8*i +: 8]) hit = 1'b0;
    end
    if (!reported && hit) begin
      res.found  = 1'b1;
      res.offset = ResOffW'(byte_count - OffsetBits'(span - 1));
      expected_q.push_back(res);
      reported = 1'b1;
    end else if (!reported && last) begin
      res = '0;
      expected_q.push_back(res);
    end
    if (last) begin
      clear_scan();
    end else begin
      for (int k = WinLen - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = b;
      if (byte_count != '1) byte_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      pat_low  = '0;
      pat_high = '0;
      wild     = '0;
      pat_len  = CfgLenW'(1);
      clear_scan();
      expected_q.delete();
    end else begin
      // a result leaving now belongs to an earlier word, so check it first
      if (out_mon.valid && out_mon.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: found %0d, match_offset %0d",
                 out_mon.found, out_mon.match_offset);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_mon.found);
            n_fail++;
          end
          if (out_mon.match_offset !== want.offset) begin
            $error("match_offset: expected %0d, actual %0d", want.offset,
                   out_mon.match_offset);
            n_fail++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          RegPatternLow:  pat_low  = pwdata;
          RegPatternHigh: pat_high = pwdata;
          RegWildMask:    wild     = pwdata[MaskW-1:0];
          RegPatternLen:  pat_len  = pwdata[CfgLenW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) scan_word(in_mon.data_byte, in_mon.last_byte);
    end
    n_pending = expected_q.size();
  end

endmodule

>>> tb/sv/wildcard_byte_pattern_scan_test.sv
`timescale 1ns / 1ps
// top of the wildcard byte pattern scan test: clock, reset, stimulus and verdict
// needs wbps_pkg, wbps_if, the block itself and wbps_scan_checker
module wildcard_byte_pattern_scan_test;
  import wbps_pkg::*;

  localparam int CycleLimit  = 100_000;
  localparam int PhaseWords  = 46;
  localparam int PhaseCount  = 12;

  logic clk_i = 1'b0;
  logic rst_ni;

  // register port
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  int fail_count;
  int pending_count;
  int result_count;

  // idling odds in percent, changed between phases
  int in_idle_pct  = 23;
  int out_idle_pct = 69;

  // what the stimulus believes is configured, used to plant pattern instances
  logic [127:0]     stim_pat;
  logic [MaskW-1:0] stim_wild;
  int               stim_span;

  int n_words    = 0;
  int n_regions  = 0;
  int n_settings = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  wildcard_byte_pattern_scan dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wbps_scan_checker scan_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // watchdog: a hung handshake or a missing result ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycle_count,
               pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: stalls at random, never when out_idle_pct is zero
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // one word on the input channel; entered and left at a falling edge, and valid
  // is left high so that back-to-back words need no second assignment in a step
  task automatic send_word(input byte_t b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    n_words++;
    @(negedge clk_i);
  endtask

  // one register write: setup cycle then access cycle; psel is lowered by the caller
  task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  // rewrite all four registers once the block is idle; this is also where the
  // sender holds off until every expected result has been taken
  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [MaskW-1:0] mask, input logic [CfgLenW-1:0] len);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    // a word without a result may still be in the window cells
    repeat (4) @(negedge clk_i);
    apb_write(RegPatternLow, lo);
    apb_write(RegPatternHigh, hi);
    apb_write(RegWildMask, DataW'(mask));
    apb_write(RegPatternLen, DataW'(len));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stim_pat  = {hi, lo};
    stim_wild = mask;
    stim_span = (len == 0) ? 1 : (len > PatLen) ? PatLen : int'(len);
    n_settings++;
  endtask

  // regions of mostly small size; most carry a planted pattern instance with
  // random bytes in wildcard slots, some carry a damaged one, the rest is noise.
  // filler favours pattern bytes so that partial matches are common.
  // a region cut short by the word budget stays open into the next setting
  task automatic run_regions(input int budget);
    byte_t region_q [$];
    int    sent;
    int    rlen;
    int    kind;
    int    at;
    int    pick;
    sent = 0;
    while (sent < budget) begin
      rlen = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      kind = $urandom_range(9);
      region_q.delete();
      for (int j = 0; j < rlen; j++) begin
        pick = $urandom_range(stim_span - 1);
        if ($urandom_range(1)) region_q.push_back(byte_t'($urandom_range(255)));
        else region_q.push_back(stim_pat[8*pick +: 8]);
      end
      if (kind != 0 && rlen >= stim_span) begin
        at = $urandom_range(rlen - stim_span);
        for (int i = 0; i < stim_span; i++)
          if (!stim_wild[i]) region_q[at+i] = stim_pat[8*i +: 8];
        if (kind == 1) begin
          pick = $urandom_range(stim_span - 1);
          region_q[at+pick] = region_q[at+pick] ^ byte_t'($urandom_range(1, 255));
        end
      end
      for (int j = 0; j < rlen && sent < budget; j++) begin
        send_word(region_q[j], j == rlen - 1);
        sent++;
      end
      n_regions++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: pattern de ad ?? ef, third byte a wildcard
    configure(64'h0000_0000_ef00_adde, 64'h0, 16'h0004, 5'd4);
    // region shorter than the pattern ends without a match
    send_word(8'hde, 1'b0);
    send_word(8'had, 1'b1);
    // match at offset 1, the trailing last byte gives no second result
    send_word(8'h00, 1'b0);
    send_word(8'hde, 1'b0);
    send_word(8'had, 1'b0);
    send_word(8'h77, 1'b0);
    send_word(8'hef, 1'b0);
    send_word(8'hff, 1'b1);
    // match completing on the last byte itself
    send_word(8'hde, 1'b0);
    send_word(8'had, 1'b0);
    send_word(8'h13, 1'b0);
    send_word(8'hef, 1'b1);
    // region left open while the length shrinks to two; window and count survive
    send_word(8'hff, 1'b0);
    send_word(8'hde, 1'b0);
    send_word(8'had, 1'b0);
    send_word(8'hff, 1'b0);
    configure(64'h0000_0000_ef00_adde, 64'h0, 16'h0004, 5'd2);
    send_word(8'hde, 1'b0);
    send_word(8'had, 1'b1);
    // single zero byte pattern against the byte extremes
    configure(64'h0, 64'h0, 16'h0000, 5'd1);
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hff, 1'b1);

    // random part: the six setting kinds in turn, spread over the three idling patterns
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == PhaseCount / 3) begin
        in_idle_pct  = 69;
        out_idle_pct = 23;
      end else if (ph == 2 * PhaseCount / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      case (ph % 6)
        0: configure({$urandom, $urandom}, {$urandom, $urandom},
                     MaskW'($urandom & $urandom), CfgLenW'($urandom_range(1, PatLen)));
        // shortest pattern, all ones byte
        1: configure('1, '0, '0, 5'd1);
        // longest pattern, every byte a wildcard
        2: configure({$urandom, $urandom}, {$urandom, $urandom}, '1, 5'd16);
        // length zero behaves as one
        3: configure({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd0);
        // lengths past the maximum clamp to sixteen
        4: configure({$urandom, $urandom}, {$urandom, $urandom},
                     MaskW'($urandom & $urandom), CfgLenW'($urandom_range(17, 31)));
        default: configure('0, '1, 16'h8001, 5'd16);
      endcase
      run_regions(PhaseWords);
    end

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("scanned %0d words in %0d regions under %0d register settings,",
             n_words, n_regions, n_settings);
    $display("%0d result words checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> wildcard_byte_pattern_scan.f
rtl/core/wbps_pkg.sv
rtl/core/wbps_if.sv
rtl/core/wbps_cfg_regs.sv
rtl/core/wbps_cell.sv
rtl/core/wildcard_byte_pattern_scan.sv
tb/sv/wbps_scan_checker.sv
tb/sv/wildcard_byte_pattern_scan_test.sv
